@@ rtl/core/serial_command_signal_controller_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the serial command signal controller
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SERIAL_COMMAND_SIGNAL_CONTROLLER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_SIGNAL_CONTROLLER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SCSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SCSC_ASSERT_NOW(lbl, ante, cons, msg)
`define SCSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/scsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsc_pkg
// Constants, types and helpers shared by the signal controller modules.
// ----------------------------------------------------------------------------
package scsc_pkg;

  localparam int NUM_SIGNALS = 4;
  localparam int PIN_W       = 4;
  localparam int SIG_IDX_W   = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int EXT_W       = (NUM_SIGNALS > PIN_W) ? NUM_SIGNALS : PIN_W;

  localparam logic [7:0] END_MARK   = 8'hE0;
  localparam logic [7:0] CMD_CLEAR  = 8'hFF;
  localparam logic [7:0] CMD_SIGNAL = 8'h20;
  localparam logic [7:0] CMD_ZONE   = 8'h10;
  localparam logic [7:0] STATUS_ID  = 8'h30;
  localparam logic [7:0] SIG_COUNT  = 8'(NUM_SIGNALS);

  localparam logic [SIG_IDX_W-1:0] LAST_IDX = SIG_IDX_W'(NUM_SIGNALS - 1);

  // byte position inside a status frame
  localparam logic [2:0] POS_ID     = 3'd0;
  localparam logic [2:0] POS_SECTOR = 3'd1;
  localparam logic [2:0] POS_NUMBER = 3'd2;
  localparam logic [2:0] POS_VALUE  = 3'd3;
  localparam logic [2:0] POS_END    = 3'd4;

  typedef logic [NUM_SIGNALS-1:0] sig_vec_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic start_report;
    logic next_report;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } dp_sts_t;

  // pins carry the inverted signal bits, unused pins low
  function automatic logic [PIN_W-1:0] pins_of(input sig_vec_t sig);
    logic [EXT_W-1:0] ext;
    ext = '0;
    ext[NUM_SIGNALS-1:0] = ~sig;
    return ext[PIN_W-1:0];
  endfunction

  function automatic logic [7:0] status_byte(input logic [2:0] pos,
                                             input logic [SIG_IDX_W-1:0] idx,
                                             input logic bit_val);
    logic [7:0] b;
    case (pos)
      POS_ID:     b = STATUS_ID;
      POS_SECTOR: b = 8'(idx);
      POS_NUMBER: b = 8'h00;
      POS_VALUE:  b = {7'b0, bit_val};
      default:    b = END_MARK;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/scsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsc channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface scsc_req_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface scsc_rsp_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] tx_byte;
  logic [3:0] pin_levels;
  logic       last;

  modport source (output valid, kind, tx_byte, pin_levels, last, input ready);
  modport sink   (input valid, kind, tx_byte, pin_levels, last, output ready);
endinterface

@@ rtl/core/serial_command_signal_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_signal_controller_unit
// Decodes five-byte serial command frames into signal pins; sends status.
// ----------------------------------------------------------------------------
//
//  channel | dir | contents
//  --------+-----+--------------------------------------------------------
//  req     | in  | func (0 byte, 1 status tick), rx_byte
//  rsp     | out | kind, tx_byte, pin_levels, last (one or more per req)
//
//  A received byte gives one result, valid the cycle after acceptance.
//  A status tick gives 5 * NUM_SIGNALS results, one per cycle while rsp
//  is ready; the single result register in the datapath sets this pace.
//  The next req is taken in the cycle the final result of the previous
//  transaction leaves, so a byte stream runs at one byte per cycle.
//  rsp stalls hold the result and the state; req waits (ready low).
//  Synchronous reset clears the byte window, signal/zone/manual bits and
//  pins; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "serial_command_signal_controller_unit_defines.svh"

module serial_command_signal_controller_unit (
  input logic        clk,
  input logic        rst,
  scsc_req_if.sink   req,
  scsc_rsp_if.source rsp
);
  import scsc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // controller: owns the handshake and decides what the datapath does
  scsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: frame decode, control bits and the result register
  scsc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .rx_byte    (req.rx_byte),
    .kind       (rsp.kind),
    .tx_byte    (rsp.tx_byte),
    .pin_levels (rsp.pin_levels)
  );

  assign rsp.last = sts.last;

  // a received byte is answered next cycle by a single pin-state result
  `SCSC_ASSERT_NEXT(a_byte_reply, req.valid && req.ready && !req.func, rsp.valid && !rsp.kind && rsp.last, "byte not answered by single pin result")
  // a status tick opens with the status frame header byte
  `SCSC_ASSERT_NEXT(a_report_start, req.valid && req.ready && req.func, rsp.valid && rsp.kind && (rsp.tx_byte == STATUS_ID) && !rsp.last, "status report start wrong")
  // pins do not move in the middle of a status report
  `SCSC_ASSERT_NEXT(a_report_pins, rsp.valid && rsp.ready && rsp.kind && !rsp.last, $stable(rsp.pin_levels) && rsp.valid && rsp.kind, "pins changed during report")
  // input is never taken while a non-final result is pending
  `SCSC_ASSERT_NOW(a_no_overlap, req.valid && req.ready && rsp.valid, rsp.ready && rsp.last, "input accepted over pending result")

endmodule

@@ rtl/core/scsc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsc_ctrl
// Handshake controller: sequences byte replies and status reports.
// ----------------------------------------------------------------------------
module scsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output scsc_pkg::dp_cmd_t cmd,
  input  scsc_pkg::dp_sts_t sts
);
  import scsc_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    REPLY,
    REPORT
  } state_t;

  state_t state;
  logic   in_acc;
  logic   out_acc;

  assign out_valid = (state != IDLE);
  assign out_acc   = out_valid && out_ready;
  // next item may enter as the final result of the current one leaves
  assign in_ready  = (state == IDLE) || (out_ready && sts.last);
  assign in_acc    = in_valid && in_ready;

  assign cmd.take_byte    = in_acc && !in_func;
  assign cmd.start_report = in_acc && in_func;
  assign cmd.next_report  = out_acc && !sts.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else if (in_acc) begin
      state <= in_func ? REPORT : REPLY;
    end else if (out_acc && sts.last) begin
      state <= IDLE;
    end
  end

endmodule

@@ rtl/core/scsc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsc_dp
// Byte window, frame decode, signal/zone/manual state and result register.
// ----------------------------------------------------------------------------
module scsc_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  scsc_pkg::dp_cmd_t           cmd,
  output scsc_pkg::dp_sts_t           sts,
  input  logic [7:0]                  rx_byte,
  output logic                        kind,
  output logic [7:0]                  tx_byte,
  output logic [scsc_pkg::PIN_W-1:0]  pin_levels
);
  import scsc_pkg::*;

  logic [7:0]           win [4];
  sig_vec_t             signal_bits, zone_bits, manual_bits;
  logic [PIN_W-1:0]     pins;
  logic [2:0]           pos;
  logic [SIG_IDX_W-1:0] idx;

  sig_vec_t         signal_next, zone_next, manual_next;
  logic [PIN_W-1:0] pins_next;
  sig_vec_t         hit;
  logic             frame_ok;
  logic             data_set;

  // frame decode: win[0] command, [1] sector, [2] number, [3] data
  always_comb begin
    for (int i = 0; i < NUM_SIGNALS; i++) begin
      hit[i] = (win[1] == 8'(i));
    end
    frame_ok    = (win[1] < SIG_COUNT) && (win[2] == 8'h00);
    data_set    = (win[3] != 8'h00);
    signal_next = signal_bits;
    zone_next   = zone_bits;
    manual_next = manual_bits;
    pins_next   = pins;
    if (rx_byte == END_MARK) begin
      case (win[0])
        CMD_CLEAR: begin
          signal_next = '0;
          zone_next   = '0;
          manual_next = '0;
        end
        CMD_SIGNAL: begin
          if (frame_ok) begin
            signal_next = data_set ? (signal_bits | hit) : (signal_bits & ~hit);
            manual_next = manual_bits ^ hit;
            pins_next   = pins_of(signal_next);
          end
        end
        CMD_ZONE: begin
          if (frame_ok) begin
            zone_next   = data_set ? (zone_bits | hit) : (zone_bits & ~hit);
            signal_next = (signal_bits & manual_bits) | (zone_next & ~manual_bits);
            pins_next   = pins_of(signal_next);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        win[i] <= 8'h00;
      end
      signal_bits <= '0;
      zone_bits   <= '0;
      manual_bits <= '0;
      pins        <= '0;
    end else if (cmd.take_byte) begin
      win[0]      <= win[1];
      win[1]      <= win[2];
      win[2]      <= win[3];
      win[3]      <= rx_byte;
      signal_bits <= signal_next;
      zone_bits   <= zone_next;
      manual_bits <= manual_next;
      pins        <= pins_next;
    end
  end

  // result register: kind plus frame position select the byte
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= 1'b0;
      pos  <= POS_ID;
      idx  <= '0;
    end else if (cmd.start_report) begin
      kind <= 1'b1;
      pos  <= POS_ID;
      idx  <= '0;
    end else if (cmd.take_byte) begin
      kind <= 1'b0;
    end else if (cmd.next_report) begin
      if (pos == POS_END) begin
        pos <= POS_ID;
        idx <= SIG_IDX_W'(idx + 1'b1);
      end else begin
        pos <= 3'(pos + 3'd1);
      end
    end
  end

  assign tx_byte    = kind ? status_byte(pos, idx, signal_bits[idx]) : 8'h00;
  assign pin_levels = pins;
  assign sts.last   = !kind || ((pos == POS_END) && (idx == LAST_IDX));

endmodule

@@ tb/serial_command_signal_controller_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_signal_controller_unit_tb
// Runs received bytes and status ticks through the serial command
// controller and compares every result transaction with a cycle-free
// prediction of the frame decoder, the signal/zone/manual bits and the pins.
// ----------------------------------------------------------------------------
module serial_command_signal_controller_unit_tb;
  import scsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;  // far beyond the slowest legal run
  localparam int          BYTE_TARGET = 470;        // stimulus stops near this many items

  // one result transaction, laid out like the rsp payload
  typedef struct packed {
    logic             kind;
    logic [7:0]       tx_byte;
    logic [PIN_W-1:0] pin_levels;
    logic             last;
  } scsc_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the controller state as the block should and holds
  // the results still owed, oldest first.
  // --------------------------------------------------------------------------
  class signal_frame_scoreboard;
    logic [7:0]       window [4] = '{default: 8'h00};  // oldest byte first
    sig_vec_t         signals = '0;
    sig_vec_t         zones   = '0;
    sig_vec_t         manuals = '0;
    logic [PIN_W-1:0] pins    = '0;   // pins start low, not inverted
    scsc_result_t     due_results [$];
    int errors    = 0;
    int n_bytes   = 0;
    int n_ticks   = 0;
    int n_applied = 0;
    int n_checked = 0;

    function void push_result(logic kind, logic [7:0] tx, logic last);
      scsc_result_t r;
      r.kind       = kind;
      r.tx_byte    = tx;
      r.pin_levels = pins;
      r.last       = last;
      due_results.push_back(r);
    endfunction

    function void decode_frame(logic [7:0] cmd, logic [7:0] sector,
                               logic [7:0] number, logic [7:0] data);
      int idx;
      if (cmd == CMD_CLEAR) begin
        // clear leaves the pins where they are
        signals = '0;
        zones   = '0;
        manuals = '0;
        n_applied++;
        return;
      end
      if (cmd != CMD_SIGNAL && cmd != CMD_ZONE) return;
      if (int'(sector) >= NUM_SIGNALS || number != 8'h00) return;
      idx = int'(sector);
      if (cmd == CMD_SIGNAL) begin
        signals[idx] = (data != 8'h00);
        manuals[idx] = ~manuals[idx];
      end else begin
        zones[idx] = (data != 8'h00);
        signals    = (signals & manuals) | (zones & ~manuals);
      end
      for (int i = 0; i < PIN_W; i++)
        pins[i] = (i < NUM_SIGNALS) ? ~signals[i] : 1'b0;
      n_applied++;
    endfunction

    function void note_item(logic func, logic [7:0] rx);
      logic [7:0] cmd, sector, number, data;
      if (!func) begin
        cmd    = window[0];
        sector = window[1];
        number = window[2];
        data   = window[3];
        window[0] = window[1];
        window[1] = window[2];
        window[2] = window[3];
        window[3] = rx;
        if (rx == END_MARK) decode_frame(cmd, sector, number, data);
        push_result(1'b0, 8'h00, 1'b1);
        n_bytes++;
      end else begin
        for (int i = 0; i < NUM_SIGNALS; i++) begin
          push_result(1'b1, STATUS_ID, 1'b0);
          push_result(1'b1, 8'(i), 1'b0);
          push_result(1'b1, 8'h00, 1'b0);
          push_result(1'b1, {7'b0, signals[i]}, 1'b0);
          push_result(1'b1, END_MARK, i == NUM_SIGNALS - 1);
        end
        n_ticks++;
      end
    endfunction

    function void check_result(scsc_result_t got);
      scsc_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d tx_byte 0x%02h pin_levels 0x%01h last %0d",
               got.kind, got.tx_byte, got.pin_levels, got.last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.pin_levels !== want.pin_levels) begin
        $error("pin_levels: expected 0x%01h, got 0x%01h", want.pin_levels, got.pin_levels);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  scsc_req_if req_ch ();
  scsc_rsp_if rsp_ch ();

  serial_command_signal_controller_unit u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  signal_frame_scoreboard sb;
  bit          burst_mode = 1'b0;  // both sides run without gaps while set
  int unsigned cycles     = 0;

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Request side. A task returns after its transaction is accepted and any gap
  // that follows; valid drops only during a gap, and the next call raises it.
  // --------------------------------------------------------------------------
  task automatic hold_off(int n);
    if (n == 0) return;
    req_ch.valid   <= 1'b0;
    req_ch.rx_byte <= 8'($urandom);  // junk while idle
    repeat (n) @(posedge clk);
  endtask

  task automatic send_item(logic func, logic [7:0] rx);
    req_ch.valid   <= 1'b1;
    req_ch.func    <= func;
    req_ch.rx_byte <= rx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_item(func, rx);
    hold_off(pick_gap());
  endtask

  task automatic send_frame(logic [7:0] cmd, logic [7:0] sector, logic [7:0] number,
                            logic [7:0] data, logic [7:0] tail);
    send_item(1'b0, cmd);
    send_item(1'b0, sector);
    send_item(1'b0, number);
    send_item(1'b0, data);
    send_item(1'b0, tail);
  endtask

  // Status tick; rx_byte is don't-care and gets random content.
  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  // Mostly well-formed frames on known commands and sectors in range;
  // some carry a stray command, sector, number or end byte.
  task automatic random_frame();
    logic [7:0] cmd, sector, number, data, tail;
    int r;
    r = $urandom_range(0, 9);
    if (r < 4)       cmd = CMD_SIGNAL;
    else if (r < 7)  cmd = CMD_ZONE;
    else if (r < 8)  cmd = CMD_CLEAR;
    else             cmd = 8'($urandom);
    sector = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, NUM_SIGNALS - 1));
    number = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00;
    data   = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom);
    tail   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : END_MARK;
    send_frame(cmd, sector, number, data, tail);
  endtask

  // Sender holds back until every owed result has been seen.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side: check at each accepted transaction, stall ready at random.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    scsc_result_t got;
    stall_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.kind       = rsp_ch.kind;
        got.tx_byte    = rsp_ch.tx_byte;
        got.pin_levels = rsp_ch.pin_levels;
        got.last       = rsp_ch.last;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!burst_mode && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("serial_command_signal_controller_unit_tb failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    bit pressed;
    sb = new;
    pressed = 1'b0;
    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.func    <= 1'b0;
    req_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: status right after reset (pins still low), set a signal,
    // zone copy that must skip the manual signal, out-of-range sector,
    // nonzero number, clear with pins held, and status again.
    send_tick();
    send_frame(CMD_SIGNAL, 8'h00, 8'h00, 8'h01, END_MARK);
    send_frame(CMD_ZONE,   8'(NUM_SIGNALS - 1), 8'h00, 8'h80, END_MARK);
    send_tick();
    send_frame(CMD_SIGNAL, 8'hFF, 8'h00, 8'h00, END_MARK);
    send_frame(CMD_ZONE,   8'h01, 8'h7F, 8'h01, END_MARK);
    send_frame(CMD_CLEAR,  8'h12, 8'h34, 8'h56, END_MARK);
    send_tick();

    // sender waits for the block to empty out once
    drain();

    // Random: frames with random content, stray bytes and rare ticks.
    while (sb.n_bytes + sb.n_ticks < BYTE_TARGET) begin
      burst_mode = ((sb.n_bytes / 60) % 4) == 3;
      if (!pressed && sb.n_bytes > 300) begin
        drain();
        pressed = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick == 0)
        send_tick();
      else if (pick < 3)
        send_item(1'b0, ($urandom_range(0, 3) == 0) ? END_MARK : 8'($urandom));
      else
        random_frame();
    end
    burst_mode = 1'b0;

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);  // nothing further may come out

    $display("covered %0d bytes and %0d status ticks, %0d frames acted on",
             sb.n_bytes, sb.n_ticks, sb.n_applied);
    $display("%0d result transactions compared, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("serial_command_signal_controller_unit_tb passed");
    end else begin
      $display("serial_command_signal_controller_unit_tb failed");
    end
    $finish;
  end

endmodule

@@ serial_command_signal_controller_unit.f @@
+incdir+rtl/core
rtl/core/scsc_pkg.sv
rtl/core/scsc_if.sv
rtl/core/scsc_ctrl.sv
rtl/core/scsc_dp.sv
rtl/core/serial_command_signal_controller_unit.sv
tb/serial_command_signal_controller_unit_tb.sv
